@@ rtl/u2u_pkg.sv @@
package u2u_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned MaxUnits = 3;

  localparam logic [PointW-1:0] BmpLimit    = 21'h00FFFF;
  localparam logic [PointW-1:0] SuppOffset  = 21'h010000;
  localparam logic [UnitW-1:0]  HighSurBase = 16'hD800;
  localparam logic [UnitW-1:0]  LowSurBase  = 16'hDC00;
  localparam logic [UnitW-1:0]  Terminator  = 16'h0000;

  // lead byte classes
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;

  // decoded results of one item, unit 0 goes out first
  typedef struct packed {
    logic [MaxUnits-1:0][UnitW-1:0] units;
    logic [1:0]                     count;
    logic                           term;
  } bundle_t;

endpackage

@@ rtl/u2u_in_if.sv @@
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       ends_string;

  modport source (output valid, output text_byte, output byte_present, output ends_string,
                  input ready);
  modport sink (input valid, input text_byte, input byte_present, input ends_string,
                output ready);
endinterface

@@ rtl/u2u_out_if.sv @@
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink (input valid, input code_unit, input final_unit, output ready);
endinterface

@@ rtl/utf8_to_utf16_transcoder.sv @@
// path: an accepted byte sits in the input register, is decoded and moves into the result
//   register once that is free; its first code unit is then shown from the result register
// throughput: one item per cycle while each item yields at most one code unit and the
//   output is ready; a surrogate pair or a unit plus terminator holds the input until sent
// reset: rst_ni is asynchronous, active low; it clears the pending sequence, the input
//   register and the result buffer, items in flight at reset are dropped
module utf8_to_utf16_transcoder (
  input  logic   clk_i,
  input  logic   rst_ni,
  u2u_in_if.sink   byte_i,
  u2u_out_if.source unit_o
);

  u2u_pkg::bundle_t bundle;
  logic             bundle_valid;
  logic             buf_free;

  // input register, utf-8 sequence state and the decode of one byte into up to
  // three utf-16 units (high half, low half, terminator)
  u2u_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (byte_i.valid),
    .in_ready_o     (byte_i.ready),
    .text_byte_i    (byte_i.text_byte),
    .byte_present_i (byte_i.byte_present),
    .ends_string_i  (byte_i.ends_string),
    .buf_free_i     (buf_free),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  // result register: holds one item's units and, while the output is ready, drains them one
  // per cycle; it frees up in the same cycle its last unit is taken
  u2u_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_i       (bundle),
    .buf_free_o     (buf_free),
    .out_valid_o    (unit_o.valid),
    .out_ready_i    (unit_o.ready),
    .code_unit_o    (unit_o.code_unit),
    .final_unit_o   (unit_o.final_unit)
  );

endmodule

@@ rtl/u2u_decode.sv @@
module u2u_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  input  logic              byte_present_i,
  input  logic              ends_string_i,
  input  logic              buf_free_i,
  output logic              bundle_valid_o,
  output u2u_pkg::bundle_t  bundle_o
);

  logic                         hold_valid_q;
  logic [7:0]                   byte_q;
  logic                         present_q;
  logic                         ends_q;
  logic [u2u_pkg::PointW-1:0]   point_q, point_d;
  logic [1:0]                   rem_q, rem_d;
  logic                         advance;
  logic                         accept;

  assign advance    = hold_valid_q && buf_free_i;
  assign in_ready_o = !hold_valid_q || buf_free_i;
  assign accept     = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q    <= text_byte_i;
      present_q <= byte_present_i;
      ends_q    <= ends_string_i;
    end
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q <= '0;
      rem_q   <= '0;
    end else if (advance) begin
      point_q <= point_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    logic                       emit;
    logic [u2u_pkg::PointW-1:0] pt;
    logic [u2u_pkg::PointW-1:0] v;
    logic [1:0]                 n;
    u2u_pkg::bundle_t           b;

    point_d = point_q;
    rem_d   = rem_q;
    emit    = 1'b0;
    pt      = '0;
    v       = '0;
    n       = '0;
    b       = '0;

    if (present_q) begin
      if (rem_q == 2'd0) begin
        if (!byte_q[7]) begin
          emit = 1'b1;
          pt   = {13'd0, byte_q};
        end else if (byte_q[7:5] == u2u_pkg::Lead2Tag) begin
          point_d = {16'd0, byte_q[4:0]};
          rem_d   = 2'd1;
        end else if (byte_q[7:4] == u2u_pkg::Lead3Tag) begin
          point_d = {17'd0, byte_q[3:0]};
          rem_d   = 2'd2;
        end else begin
          point_d = {18'd0, byte_q[2:0]};
          rem_d   = 2'd3;
        end
      end else begin
        pt    = {point_q[14:0], byte_q[5:0]};
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          emit    = 1'b1;
          point_d = '0;
        end else begin
          point_d = pt;
        end
      end
    end

    if (emit) begin
      if (pt > u2u_pkg::BmpLimit) begin
        v          = pt - u2u_pkg::SuppOffset;
        b.units[0] = u2u_pkg::HighSurBase + {5'd0, v[20:10]};
        b.units[1] = u2u_pkg::LowSurBase | {6'd0, v[9:0]};
        n          = 2'd2;
      end else begin
        b.units[0] = pt[15:0];
        n          = 2'd1;
      end
    end

    if (ends_q) begin
      point_d    = '0;
      rem_d      = '0;
      b.units[n] = u2u_pkg::Terminator;
      n          = n + 2'd1;
      b.term     = 1'b1;
    end

    b.count        = n;
    bundle_o       = b;
    bundle_valid_o = advance && (n != 2'd0);
  end

endmodule

@@ rtl/u2u_out_buf.sv @@
module u2u_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              bundle_valid_i,
  input  u2u_pkg::bundle_t  bundle_i,
  output logic              buf_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       code_unit_o,
  output logic              final_unit_o
);

  logic [u2u_pkg::MaxUnits-1:0][u2u_pkg::UnitW-1:0] units_q, units_d;
  logic [1:0] cnt_q, cnt_d;
  logic       term_q, term_d;
  logic       take;

  assign out_valid_o  = (cnt_q != 2'd0);
  assign take         = out_valid_o && out_ready_i;
  assign buf_free_o   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign code_unit_o  = units_q[0];
  assign final_unit_o = term_q && (cnt_q == 2'd1);

  always_comb begin
    units_d = units_q;
    cnt_d   = cnt_q;
    term_d  = term_q;
    if (bundle_valid_i) begin
      units_d = bundle_i.units;
      cnt_d   = bundle_i.count;
      term_d  = bundle_i.term;
    end else if (take) begin
      // shift the next unit to the head
      units_d = {{u2u_pkg::UnitW{1'b0}}, units_q[2:1]};
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      term_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    units_q <= units_d;
  end

endmodule

@@ rtl/u2u_checker.sv @@
module u2u_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] code_unit_i,
  input logic        final_unit_i
);

  // a stalled unit holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_unit_i)
                                    && $stable(final_unit_i))
    else $error("output unit changed while stalled");

  // the terminator is always zero
  a_final_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && final_unit_i |-> code_unit_i == 16'h0000)
    else $error("final unit is not zero");

  // input only back-pressures while a unit waits at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .out_valid_i  (unit_o.valid),
  .out_ready_i  (unit_o.ready),
  .code_unit_i  (unit_o.code_unit),
  .final_unit_i (unit_o.final_unit)
);
